// File: rtl/core/scc_pkg.sv
// ============================================================================
// scc_pkg
// Shared types and constants for the strongly connected components block.
// ============================================================================
package scc_pkg;

    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 256;
    localparam int VW          = $clog2(MaxVertices);
    localparam int EW          = $clog2(MaxEdges);
    localparam int CW          = EW + 1;
    localparam int NW          = 7;

    typedef enum logic [1:0] {
        ACT_LABEL = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_P1_SCAN,
        ST_P1_TEST,
        ST_WALK,
        ST_EDGE,
        ST_SEEN,
        ST_POP,
        ST_P2_POP,
        ST_P2_FRD,
        ST_P2_TEST,
        ST_EMIT,
        ST_EMIT_WAIT,
        ST_DRAIN
    } t_state;

    // Result item travelling to the output register
    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [7:0]    label;
        logic [VW-1:0] comp;
        logic          comp_end;
        logic          last;
    } t_result;

endpackage

// File: rtl/core/strongly_connected_components.sv
// ============================================================================
// strongly_connected_components
// Kosaraju strongly connected components over a loaded directed graph.
// ============================================================================
// Usage: the input channel takes load and run transactions. Label, edge and
// clear transactions may come back to back. A run transaction clears the seen
// marks, walks the forward graph, clears again, then walks the reversed graph
// in finish order and returns one output transaction per vertex, grouped by
// component. Each vertex visit scans every stored edge through the single
// edge-memory read port. The input stays not ready from a run until its final
// transaction has been accepted; a run with no vertices returns nothing.
// A stalled receiver holds the walk; nothing is lost or reordered.
// Reset clears labels, edge count and the vertex_count register (to 64).
// The configuration channel writes vertex_count; write it only while idle.
// ============================================================================
module strongly_connected_components (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [5:0] i_vertex,
    input  logic [7:0] i_label,
    input  logic [5:0] i_edge_from,
    input  logic [5:0] i_edge_to,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [5:0] o_out_vertex,
    output logic [7:0] o_out_label,
    output logic [5:0] o_component_number,
    output logic       o_component_end,
    output logic       o_last
);
    import scc_pkg::*;

    logic [NW-1:0] r_count;
    t_result       res;

    // Configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= NW'(MaxVertices);
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    scc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_vertex    (i_vertex),
        .i_label     (i_label),
        .i_edge_from (i_edge_from),
        .i_edge_to   (i_edge_to),
        .i_count     (r_count),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_out_vertex       = res.vertex;
    assign o_out_label        = res.label;
    assign o_component_number = res.comp;
    assign o_component_end    = res.comp_end;
    assign o_last             = res.last;

endmodule

// File: rtl/core/scc_edge_mem.sv
// ============================================================================
// scc_edge_mem
// Edge store: source and target per entry, one write and one read port.
// ============================================================================
module scc_edge_mem (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [scc_pkg::EW-1:0] i_waddr,
    input  logic [scc_pkg::VW-1:0] i_wsrc,
    input  logic [scc_pkg::VW-1:0] i_wdst,
    input  logic [scc_pkg::EW-1:0] i_raddr,
    output logic [scc_pkg::VW-1:0] o_rsrc,
    output logic [scc_pkg::VW-1:0] o_rdst
);
    import scc_pkg::*;

    logic [2*VW-1:0] mem [MaxEdges];
    logic [2*VW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wsrc, i_wdst};
        end
        r_rd <= mem[i_raddr];
    end

    assign o_rsrc = r_rd[2*VW-1:VW];
    assign o_rdst = r_rd[VW-1:0];

endmodule

// File: rtl/core/scc_core.sv
// ============================================================================
// scc_core
// Sequencer for both depth-first passes; holds labels, marks and stacks.
// ============================================================================
module scc_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_action,
    input  logic [scc_pkg::VW-1:0]  i_vertex,
    input  logic [7:0]              i_label,
    input  logic [scc_pkg::VW-1:0]  i_edge_from,
    input  logic [scc_pkg::VW-1:0]  i_edge_to,
    input  logic [scc_pkg::NW-1:0]  i_count,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output scc_pkg::t_result        o_res
);
    import scc_pkg::*;

    t_state r_state, n_state;

    // Effective vertex count, clamped to the store
    logic [NW-1:0] cnt_n;
    assign cnt_n = (i_count > NW'(MaxVertices)) ? NW'(MaxVertices) : i_count;

    // Label store; valid bits make unwritten labels read as zero
    logic [7:0]             lab_mem [MaxVertices];
    logic [7:0]             r_lab_rd;
    logic [MaxVertices-1:0] r_lvalid;

    // Seen marks, walk stack (vertex, cursor) and finish stack memories
    logic             seen_mem [MaxVertices];
    logic             r_seen_rd;
    logic [VW+CW-1:0] wmem [MaxVertices];
    logic [VW-1:0]    fmem [MaxVertices];
    logic [VW+CW-1:0] r_wrd;
    logic [VW-1:0]    r_frd;

    // Sequencer registers; the top of the walk stack lives in r_cv / r_cur
    logic [CW-1:0] r_etot, n_etot;
    logic [NW-1:0] r_depth, n_depth, r_ftop, n_ftop, r_scan, n_scan;
    logic          r_rev, n_rev;
    logic [VW-1:0] r_cv, n_cv, r_w, n_w;
    logic [CW-1:0] r_cur, n_cur;
    logic [VW-1:0] r_comp, n_comp;

    // Memory control
    logic             s_we;
    logic [VW-1:0]    s_wa;
    logic             s_wd;
    logic [VW-1:0]    s_ra;
    logic             w_we;
    logic [VW-1:0]    w_wa;
    logic [VW+CW-1:0] w_wd;
    logic [VW-1:0]    w_ra;
    logic             f_we;
    logic [VW-1:0]    f_ra;
    logic [VW-1:0]    l_ra;
    logic             e_we;
    logic [EW-1:0]    e_ra;
    logic [VW-1:0]    e_src, e_dst;

    // Output register plus one held pending item (end flags decided later)
    t_result r_out, n_out;
    logic    r_ov, n_ov;
    t_result r_pend, n_pend;
    logic    r_pv, n_pv;

    scc_edge_mem u_edges (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (r_etot[EW-1:0]),
        .i_wsrc  (i_edge_from),
        .i_wdst  (i_edge_to),
        .i_raddr (e_ra),
        .o_rsrc  (e_src),
        .o_rdst  (e_dst)
    );

    logic accept;
    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE) && !r_ov && !r_pv;

    // Label store
    always_ff @(posedge i_clk) begin
        if (accept && i_action == ACT_LABEL) begin
            lab_mem[i_vertex] <= i_label;
        end
        r_lab_rd <= lab_mem[l_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvalid <= '0;
        end else if (accept && i_action == ACT_LABEL) begin
            r_lvalid[i_vertex] <= 1'b1;
        end
    end

    // Seen marks and stack memories
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            seen_mem[s_wa] <= s_wd;
        end
        if (w_we) begin
            wmem[w_wa] <= w_wd;
        end
        if (f_we) begin
            fmem[r_ftop[VW-1:0]] <= r_cv;
        end
        r_seen_rd <= seen_mem[s_ra];
        r_wrd     <= wmem[w_ra];
        r_frd     <= fmem[f_ra];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_etot  <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            r_depth <= '0;
            r_ftop  <= '0;
            r_scan  <= '0;
            r_rev   <= 1'b0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_etot  <= n_etot;
            r_ov    <= n_ov;
            r_pv    <= n_pv;
            r_depth <= n_depth;
            r_ftop  <= n_ftop;
            r_scan  <= n_scan;
            r_rev   <= n_rev;
            r_comp  <= n_comp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cv   <= n_cv;
        r_w    <= n_w;
        r_cur  <= n_cur;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    // Edge read back: direction picks which end must match the top vertex
    logic [VW-1:0] ea, eb;
    logic          edge_hit;
    assign ea = r_rev ? e_dst : e_src;
    assign eb = r_rev ? e_src : e_dst;
    assign edge_hit = (ea == r_cv) && ({1'b0, ea} < cnt_n) && ({1'b0, eb} < cnt_n);

    always_comb begin
        n_state = r_state;
        n_etot  = r_etot;
        n_depth = r_depth;
        n_ftop  = r_ftop;
        n_scan  = r_scan;
        n_rev   = r_rev;
        n_cv    = r_cv;
        n_w     = r_w;
        n_cur   = r_cur;
        n_comp  = r_comp;
        n_out   = r_out;
        n_ov    = r_ov;
        n_pend  = r_pend;
        n_pv    = r_pv;
        s_we = 1'b0;
        s_wa = r_scan[VW-1:0];
        s_wd = 1'b0;
        s_ra = '0;
        w_we = 1'b0;
        w_wa = VW'(r_depth - NW'(1));
        w_wd = {r_cv, r_cur};
        w_ra = VW'(r_depth - NW'(2));
        f_we = 1'b0;
        f_ra = VW'(r_ftop - NW'(1));
        l_ra = r_w;
        e_we = 1'b0;
        e_ra = EW'(r_cur - CW'(1));

        // Output handshake: drain the output register
        if (r_ov && i_res_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_action'(i_action))
                        ACT_LABEL: ;
                        ACT_EDGE: begin
                            if (r_etot < CW'(MaxEdges) && {1'b0, i_edge_from} < cnt_n
                                && {1'b0, i_edge_to} < cnt_n) begin
                                e_we   = 1'b1;
                                n_etot = r_etot + CW'(1);
                            end
                        end
                        ACT_CLEAR: n_etot = '0;
                        ACT_RUN: begin
                            n_rev   = 1'b0;
                            n_scan  = '0;
                            n_ftop  = '0;
                            n_depth = '0;
                            n_comp  = '0;
                            n_state = ST_CLR;
                        end
                    endcase
                end
            end
            // Clear seen marks of the active vertices, one per cycle
            ST_CLR: begin
                if (r_scan >= cnt_n) begin
                    n_scan  = '0;
                    n_state = r_rev ? ST_P2_POP : ST_P1_SCAN;
                end else begin
                    s_we   = 1'b1;
                    n_scan = r_scan + NW'(1);
                end
            end
            // Pass one: next root in index order
            ST_P1_SCAN: begin
                if (r_scan >= cnt_n) begin
                    n_rev   = 1'b1;
                    n_scan  = '0;
                    n_state = ST_CLR;
                end else begin
                    s_ra    = r_scan[VW-1:0];
                    n_state = ST_P1_TEST;
                end
            end
            ST_P1_TEST: begin
                n_scan  = r_scan + NW'(1);
                n_state = ST_P1_SCAN;
                if (!r_seen_rd) begin
                    s_we    = 1'b1;
                    s_wd    = 1'b1;
                    n_cv    = r_scan[VW-1:0];
                    n_cur   = r_etot;
                    n_depth = NW'(1);
                    n_state = ST_WALK;
                end
            end
            // Fetch the next older edge, or finish the top vertex
            ST_WALK: begin
                if (r_cur != '0) begin
                    n_cur   = r_cur - CW'(1);
                    n_state = ST_EDGE;
                end else begin
                    if (!r_rev && r_ftop < NW'(MaxVertices)) begin
                        f_we   = 1'b1;
                        n_ftop = r_ftop + NW'(1);
                    end
                    n_depth = r_depth - NW'(1);
                    if (r_depth == NW'(1)) begin
                        if (r_rev) begin
                            // component closes on the last emitted vertex
                            n_pend.comp_end = 1'b1;
                            n_comp  = r_comp + VW'(1);
                            n_state = ST_P2_POP;
                        end else begin
                            n_state = ST_P1_SCAN;
                        end
                    end else begin
                        n_state = ST_POP;
                    end
                end
            end
            // Parent entry read back
            ST_POP: begin
                n_cv    = r_wrd[VW+CW-1:CW];
                n_cur   = r_wrd[CW-1:0];
                n_state = ST_WALK;
            end
            // Edge data valid: look up the neighbor's mark on a match
            ST_EDGE: begin
                n_state = ST_WALK;
                if (edge_hit) begin
                    s_ra    = eb;
                    n_w     = eb;
                    n_state = ST_SEEN;
                end
            end
            // Descend into an unseen neighbor
            ST_SEEN: begin
                n_state = ST_WALK;
                if (!r_seen_rd && r_depth < NW'(MaxVertices)) begin
                    w_we    = 1'b1;
                    s_we    = 1'b1;
                    s_wa    = r_w;
                    s_wd    = 1'b1;
                    n_cv    = r_w;
                    n_cur   = r_etot;
                    n_depth = r_depth + NW'(1);
                    if (r_rev) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            // Pass two: pop the finish stack
            ST_P2_POP: begin
                if (r_ftop == '0) begin
                    if (r_pv) begin
                        n_pend.last = 1'b1;
                        n_state     = ST_DRAIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_ftop  = r_ftop - NW'(1);
                    n_state = ST_P2_FRD;
                end
            end
            ST_P2_FRD: begin
                s_ra    = r_frd;
                n_w     = r_frd;
                n_state = ST_P2_TEST;
            end
            ST_P2_TEST: begin
                n_state = ST_P2_POP;
                if ({1'b0, r_w} < cnt_n && !r_seen_rd) begin
                    s_we    = 1'b1;
                    s_wa    = r_w;
                    s_wd    = 1'b1;
                    n_cv    = r_w;
                    n_cur   = r_etot;
                    n_depth = NW'(1);
                    n_state = ST_EMIT;
                end
            end
            // Label read issued this cycle
            ST_EMIT: begin
                n_state = ST_EMIT_WAIT;
            end
            // Shift pending into the output register, new vertex to pending
            ST_EMIT_WAIT: begin
                if (!r_pv || !r_ov || i_res_ready) begin
                    if (r_pv) begin
                        n_out = r_pend;
                        n_ov  = 1'b1;
                    end
                    n_pv            = 1'b1;
                    n_pend.vertex   = r_w;
                    n_pend.label    = r_lvalid[r_w] ? r_lab_rd : 8'd0;
                    n_pend.comp     = r_comp;
                    n_pend.comp_end = 1'b0;
                    n_pend.last     = 1'b0;
                    n_state         = ST_WALK;
                end
            end
            // Final transaction of the run
            ST_DRAIN: begin
                if (!r_ov || i_res_ready) begin
                    n_out   = r_pend;
                    n_ov    = 1'b1;
                    n_pv    = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

endmodule

// File: rtl/core/scc_checker.sv
// ============================================================================
// scc_checker
// Port-level checks for the strongly connected components block.
// ============================================================================
module scc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_last,
    input logic o_component_end
);
    // No new transaction accepted while results are pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("ready while output pending");

    // An accepted input transaction never overlaps an output transaction
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !o_out_valid) else $error("input during output");

    // The final result always closes a component
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> o_component_end) else $error("last without end");

    // Output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("output dropped");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_last          (o_last),
    .o_component_end (o_component_end)
);
